### rtl/tth_pkg.sv
// Package for the temperature trend/history tracker.
// Constants, request and trend codes, register indexes. No dependencies.
package tth_pkg;

    localparam int HIST_DEPTH = 6;
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
    localparam int IDX_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    localparam logic signed [15:0] EMPTY_MARK = 16'sd15984;
    localparam logic signed [15:0] HIGH_MARK  = -16'sd15984;

    // request kinds
    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_TREND  = 2'd1;
    localparam logic [1:0] REQ_HIST   = 2'd2;

    // trend codes
    localparam logic [1:0] TREND_STEADY  = 2'd0;
    localparam logic [1:0] TREND_RISING  = 2'd1;
    localparam logic [1:0] TREND_FALLING = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_HIST_INTERVAL  = 3'd0;
    localparam logic [2:0] CFG_TREND_INTERVAL = 3'd1;
    localparam logic [2:0] CFG_TREND_STALE    = 3'd2;
    localparam logic [2:0] CFG_TREND_THRESH   = 3'd3;
    localparam logic [2:0] CFG_VALID_LOW      = 3'd4;
    localparam logic [2:0] CFG_VALID_HIGH     = 3'd5;

    localparam logic [31:0] RST_HIST_INTERVAL  = 32'd3600000;
    localparam logic [31:0] RST_TREND_INTERVAL = 32'd600000;
    localparam logic [31:0] RST_TREND_STALE    = 32'd1200000;
    localparam logic [14:0] RST_TREND_THRESH   = 15'd16;
    localparam logic signed [15:0] RST_VALID_LOW  = -16'sd800;
    localparam logic signed [15:0] RST_VALID_HIGH = 16'sd1600;

    typedef logic signed [15:0] temp_t;

endpackage

### rtl/tth_if.sv
// Valid/ready channel interfaces for tracker requests and results.
// Depends on tth_pkg.
interface tth_req_if;
    import tth_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    temp_t       temp;
    logic [31:0] now_ms;
    logic [3:0]  hist_index;

    modport source (output valid, output req_type, output temp, output now_ms,
                    output hist_index, input ready);
    modport sink   (input valid, input req_type, input temp, input now_ms,
                    input hist_index, output ready);
endinterface

interface tth_rsp_if;
    import tth_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  trend_code;
    temp_t       min_temp;
    temp_t       max_temp;
    temp_t       hist_value;
    logic [2:0]  hist_filled;
    logic        shifted;

    modport source (output valid, output trend_code, output min_temp, output max_temp,
                    output hist_value, output hist_filled, output shifted, input ready);
    modport sink   (input valid, input trend_code, input min_temp, input max_temp,
                    input hist_value, input hist_filled, input shifted, output ready);
endinterface

### rtl/temperature_trend_history_tracker.sv
// Temperature trend and history tracker, top level.
// Path: input reg, then result reg; state updates as a request leaves the input reg.
// Throughput: one request per cycle while rsp.ready does not stall the result reg.
// Reset: min/max and history to their sentinels, fill/snapshot cleared,
// configuration registers to their defaults. Depends on tth_pkg, tth_if.
module temperature_trend_history_tracker
    import tth_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tth_req_if.sink      req,
    tth_rsp_if.source    rsp,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    // configuration
    logic [31:0] hist_interval_reg;
    logic [31:0] trend_interval_reg;
    logic [31:0] trend_stale_reg;
    logic [14:0] trend_thresh_reg;
    temp_t       valid_low_reg;
    temp_t       valid_high_reg;

    // input stage
    logic        in_valid_reg;
    logic [1:0]  in_type_reg;
    temp_t       in_temp_reg;
    logic [31:0] in_now_reg;
    logic [3:0]  in_idx_reg;

    // tracker state
    temp_t             low_reg, low_next;
    temp_t             high_reg, high_next;
    temp_t             log_reg [HIST_DEPTH];
    temp_t             log_next [HIST_DEPTH];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0]       last_shift_reg, last_shift_next;
    temp_t             snap_temp_reg, snap_temp_next;
    logic [31:0]       snap_time_reg, snap_time_next;
    logic              snap_valid_reg, snap_valid_next;

    // result stage
    logic        out_valid_reg;
    logic [1:0]  trend_reg, trend_next;
    temp_t       hval_reg, hval_next;
    logic        shifted_reg, shifted_next;
    temp_t       min_out_reg, max_out_reg;
    logic [2:0]  filled_out_reg;

    logic        advance;
    logic        in_sample_ok;
    logic        in_query_ok;
    logic        shift_due;
    logic        snap_due;
    logic [31:0] since_shift;
    logic [31:0] since_snap;
    logic signed [17:0] diff;
    logic signed [17:0] thresh;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_interval_reg  <= RST_HIST_INTERVAL;
            trend_interval_reg <= RST_TREND_INTERVAL;
            trend_stale_reg    <= RST_TREND_STALE;
            trend_thresh_reg   <= RST_TREND_THRESH;
            valid_low_reg      <= RST_VALID_LOW;
            valid_high_reg     <= RST_VALID_HIGH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HIST_INTERVAL:  hist_interval_reg  <= cfg_data;
                CFG_TREND_INTERVAL: trend_interval_reg <= cfg_data;
                CFG_TREND_STALE:    trend_stale_reg    <= cfg_data;
                CFG_TREND_THRESH:   trend_thresh_reg   <= cfg_data[14:0];
                CFG_VALID_LOW:      valid_low_reg      <= cfg_data[15:0];
                CFG_VALID_HIGH:     valid_high_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_type_reg <= req.req_type;
            in_temp_reg <= req.temp;
            in_now_reg  <= req.now_ms;
            in_idx_reg  <= req.hist_index;
        end
    end

    assign since_shift  = in_now_reg - last_shift_reg;
    assign since_snap   = in_now_reg - snap_time_reg;
    assign in_sample_ok = (in_temp_reg > valid_low_reg) && (in_temp_reg < valid_high_reg);
    assign in_query_ok  = (in_temp_reg >= valid_low_reg) && (in_temp_reg <= valid_high_reg)
                          && snap_valid_reg && (since_snap <= trend_stale_reg);
    assign shift_due    = (last_shift_reg == 32'd0) || (since_shift >= hist_interval_reg);
    assign snap_due     = !snap_valid_reg || (since_snap >= trend_interval_reg);
    assign diff         = 18'(in_temp_reg) - 18'(snap_temp_reg);
    assign thresh       = 18'(signed'({1'b0, trend_thresh_reg}));

    always_comb
    begin
        low_next        = low_reg;
        high_next       = high_reg;
        log_next        = log_reg;
        fill_next       = fill_reg;
        last_shift_next = last_shift_reg;
        snap_temp_next  = snap_temp_reg;
        snap_time_next  = snap_time_reg;
        snap_valid_next = snap_valid_reg;
        trend_next      = TREND_STEADY;
        hval_next       = EMPTY_MARK;
        shifted_next    = 1'b0;

        unique case (in_type_reg)
            REQ_UPDATE:
            begin
                if (in_sample_ok && (in_temp_reg < low_reg))
                    low_next = in_temp_reg;
                if (in_sample_ok && (in_temp_reg > high_reg))
                    high_next = in_temp_reg;
                if (shift_due)
                begin
                    for (int i = HIST_DEPTH - 1; i > 0; i--)
                        log_next[i] = log_reg[i-1];
                    log_next[0] = in_temp_reg;
                    if (32'(fill_reg) < HIST_DEPTH)
                        fill_next = fill_reg + 1'b1;
                    last_shift_next = in_now_reg;
                    shifted_next    = 1'b1;
                end
                if (snap_due)
                begin
                    snap_temp_next  = in_temp_reg;
                    snap_time_next  = in_now_reg;
                    snap_valid_next = 1'b1;
                end
            end
            REQ_TREND:
            begin
                if (in_query_ok && (diff > thresh))
                    trend_next = TREND_RISING;
                else if (in_query_ok && (diff < -thresh))
                    trend_next = TREND_FALLING;
            end
            REQ_HIST:
            begin
                if ((32'(in_idx_reg) < HIST_DEPTH) && (32'(in_idx_reg) < 32'(fill_reg)))
                    hval_next = log_reg[in_idx_reg[IDX_W-1:0]];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg        <= EMPTY_MARK;
            high_reg       <= HIGH_MARK;
            for (int i = 0; i < HIST_DEPTH; i++)
                log_reg[i] <= EMPTY_MARK;
            fill_reg       <= '0;
            last_shift_reg <= '0;
            snap_temp_reg  <= '0;
            snap_time_reg  <= '0;
            snap_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            low_reg        <= low_next;
            high_reg       <= high_next;
            log_reg        <= log_next;
            fill_reg       <= fill_next;
            last_shift_reg <= last_shift_next;
            snap_temp_reg  <= snap_temp_next;
            snap_time_reg  <= snap_time_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            trend_reg      <= trend_next;
            hval_reg       <= hval_next;
            shifted_reg    <= shifted_next;
            min_out_reg    <= low_next;
            max_out_reg    <= high_next;
            filled_out_reg <= 3'(fill_next);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.trend_code  = trend_reg;
    assign rsp.min_temp    = min_out_reg;
    assign rsp.max_temp    = max_out_reg;
    assign rsp.hist_value  = hval_reg;
    assign rsp.hist_filled = filled_out_reg;
    assign rsp.shifted     = shifted_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= HIST_DEPTH)
        else $error("history fill count beyond depth");

    a_snap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid_reg |=> snap_valid_reg)
        else $error("trend snapshot lost after being taken");

    a_trend_needs_snap: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.trend_code != TREND_STEADY)) |-> snap_valid_reg)
        else $error("trend reported without a snapshot");

    a_shift_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && shifted_next) |=> (fill_reg != '0))
        else $error("history shift left fill count at zero");

endmodule

### sim/temperature_trend_history_tracker_tb.sv
// Self-checking testbench for temperature_trend_history_tracker: directed table, then
// random phases under several register settings, results checked against a local tracker.
// Depends on rtl/tth_pkg.sv, rtl/tth_if.sv and the tracker top level.
`timescale 1ns / 1ps

module temperature_trend_history_tracker_tb;
    import tth_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;
    localparam int NUM_REGS    = 6;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int IDLE_LIMIT  = 500;

    typedef struct packed {
        logic [1:0]  kind;
        temp_t       temp;
        logic [31:0] now;
        logic [3:0]  idx;
    } tth_request_t;

    typedef struct packed {
        logic [1:0] trend;
        temp_t      lo_temp;
        temp_t      hi_temp;
        temp_t      hval;
        logic [2:0] filled;
        logic       shifted;
    } tth_result_t;

    typedef struct {
        tth_request_t rq;
        bit           fixed;
        tth_result_t  want;
    } plan_row_t;

    typedef logic [31:0] reg_set_t [NUM_REGS];

    localparam tth_result_t AT_RESET = '{TREND_STEADY, EMPTY_MARK, HIGH_MARK, EMPTY_MARK,
                                         3'd0, 1'b0};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    tth_req_if req_ch ();
    tth_rsp_if rsp_ch ();

    temperature_trend_history_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // tracker state mirrored by the scoreboard
    temp_t       lowest_t;
    temp_t       highest_t;
    temp_t       hour_log [HIST_DEPTH];
    int          log_fill;
    logic [31:0] last_shift;
    temp_t       snap_temp;
    logic [31:0] snap_at;
    bit          snap_ok;
    logic [31:0] hist_gap;
    logic [31:0] trend_gap;
    logic [31:0] stale_gap;
    logic [14:0] slope_min;
    temp_t       win_lo;
    temp_t       win_hi;

    tth_result_t due_replies [$];
    plan_row_t   plan [$];
    bit          row_fixed;
    tth_result_t row_want;

    int errors;
    int n_replies;
    int n_kind [4];
    int n_rising;
    int n_falling;
    int n_shifts;
    int n_settings;
    int idle_cycles;

    // stimulus shaping
    bit          calm_tx;
    bit          calm_rx;
    logic [31:0] now_clock;
    int          last_update_temp;
    int          gen_span;
    logic [31:0] gen_hist;
    logic [31:0] gen_trend;
    logic [31:0] gen_stale;
    int          gen_slope;
    int          gen_lo;
    int          gen_hi;

    task automatic reset_tracker();
        int i;
        lowest_t   = EMPTY_MARK;
        highest_t  = HIGH_MARK;
        for (i = 0; i < HIST_DEPTH; i++)
            hour_log[i] = EMPTY_MARK;
        log_fill   = 0;
        last_shift = '0;
        snap_temp  = '0;
        snap_at    = '0;
        snap_ok    = 1'b0;
        hist_gap   = RST_HIST_INTERVAL;
        trend_gap  = RST_TREND_INTERVAL;
        stale_gap  = RST_TREND_STALE;
        slope_min  = RST_TREND_THRESH;
        win_lo     = RST_VALID_LOW;
        win_hi     = RST_VALID_HIGH;
    endtask

    task automatic apply_reg(input logic [2:0] index, input logic [31:0] data);
        case (index)
            CFG_HIST_INTERVAL:  hist_gap  = data;
            CFG_TREND_INTERVAL: trend_gap = data;
            CFG_TREND_STALE:    stale_gap = data;
            CFG_TREND_THRESH:   slope_min = data[14:0];
            CFG_VALID_LOW:      win_lo    = data[15:0];
            CFG_VALID_HIGH:     win_hi    = data[15:0];
            default: ;
        endcase
    endtask

    function automatic tth_result_t advance_tracker(input tth_request_t rq);
        tth_result_t res;
        temp_t       t;
        logic [31:0] age;
        int          delta;
        int          i;
        res = AT_RESET;
        t = rq.temp;
        case (rq.kind)
            REQ_UPDATE:
            begin
                if (t > win_lo && t < win_hi)
                begin
                    if (t < lowest_t)
                        lowest_t = t;
                    if (t > highest_t)
                        highest_t = t;
                end
                age = rq.now - last_shift;
                if (last_shift == '0 || age >= hist_gap)
                begin
                    for (i = HIST_DEPTH - 1; i > 0; i--)
                        hour_log[i] = hour_log[i - 1];
                    hour_log[0] = t;
                    if (log_fill < HIST_DEPTH)
                        log_fill++;
                    last_shift  = rq.now;
                    res.shifted = 1'b1;
                end
                age = rq.now - snap_at;
                if (!snap_ok || age >= trend_gap)
                begin
                    snap_temp = t;
                    snap_at   = rq.now;
                    snap_ok   = 1'b1;
                end
            end
            REQ_TREND:
            begin
                age = rq.now - snap_at;
                if (t <= win_hi && t >= win_lo && snap_ok && age <= stale_gap)
                begin
                    delta = int'(t) - int'(snap_temp);
                    if (delta > int'(slope_min))
                        res.trend = TREND_RISING;
                    else if (delta < -int'(slope_min))
                        res.trend = TREND_FALLING;
                end
            end
            REQ_HIST:
            begin
                if (rq.idx < HIST_DEPTH && rq.idx < log_fill)
                    res.hval = hour_log[rq.idx];
            end
            default: ;
        endcase
        res.lo_temp = lowest_t;
        res.hi_temp = highest_t;
        res.filled  = 3'(log_fill);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        errors++;
        if (errors <= 40)
            $display("[%0t] result %0d: %s is %0d, expected %0d",
                     $realtime, n_replies, what, got_v, want_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        tth_request_t rq;
        tth_result_t  got;
        tth_result_t  want;
        if (!rst_n)
        begin
            reset_tracker();
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{rsp_ch.trend_code, rsp_ch.min_temp, rsp_ch.max_temp,
                        rsp_ch.hist_value, rsp_ch.hist_filled, rsp_ch.shifted};
                if (due_replies.size() == 0)
                begin
                    report_mismatch("result with no request pending", 1, 0);
                end
                else
                begin
                    want = due_replies.pop_front();
                    if (got.trend !== want.trend)
                        report_mismatch("trend_code", got.trend, want.trend);
                    if (got.lo_temp !== want.lo_temp)
                        report_mismatch("min_temp", got.lo_temp, want.lo_temp);
                    if (got.hi_temp !== want.hi_temp)
                        report_mismatch("max_temp", got.hi_temp, want.hi_temp);
                    if (got.hval !== want.hval)
                        report_mismatch("hist_value", got.hval, want.hval);
                    if (got.filled !== want.filled)
                        report_mismatch("hist_filled", got.filled, want.filled);
                    if (got.shifted !== want.shifted)
                        report_mismatch("shifted", got.shifted, want.shifted);
                end
                n_replies++;
            end
            if (cfg_we)
                apply_reg(cfg_index, cfg_data);
            if (req_ch.valid && req_ch.ready)
            begin
                rq = '{req_ch.req_type, req_ch.temp, req_ch.now_ms, req_ch.hist_index};
                want = advance_tracker(rq);
                if (row_fixed)
                    want = row_want;
                due_replies.push_back(want);
                n_kind[rq.kind]++;
                n_shifts += want.shifted;
                if (want.trend == TREND_RISING)
                    n_rising++;
                if (want.trend == TREND_FALLING)
                    n_falling++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[%0t] timeout: no request or result moved for %0d cycles, %0d pending",
                     $realtime, idle_cycles, due_replies.size());
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = calm_rx ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    task automatic send_request(input tth_request_t r, input bit fixed, input tth_result_t w);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= r.kind;
        req_ch.temp       <= r.temp;
        req_ch.now_ms     <= r.now;
        req_ch.hist_index <= r.idx;
        row_fixed         <= fixed;
        row_want          <= w;
        if (r.kind == REQ_UPDATE)
            last_update_temp = int'(r.temp);
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (due_replies.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic add_row(input logic [1:0] k, input int t, input logic [31:0] n,
                           input logic [3:0] ix, input bit fx, input tth_result_t w);
        plan_row_t row;
        row.rq    = '{k, 16'(t), n, ix};
        row.fixed = fx;
        row.want  = w;
        plan.push_back(row);
    endtask

    function automatic reg_set_t make_regs(input logic [31:0] hist, input logic [31:0] trend,
                                           input logic [31:0] stale, input logic [31:0] slope,
                                           input logic [31:0] lo, input logic [31:0] hi);
        reg_set_t v;
        v[CFG_HIST_INTERVAL]  = hist;
        v[CFG_TREND_INTERVAL] = trend;
        v[CFG_TREND_STALE]    = stale;
        v[CFG_TREND_THRESH]   = slope;
        v[CFG_VALID_LOW]      = lo;
        v[CFG_VALID_HIGH]     = hi;
        return v;
    endfunction

    task automatic program_regs(input reg_set_t v, input int span);
        logic [31:0] word;
        int i;
        for (i = 0; i < NUM_REGS; i++)
        begin
            word = v[i];
            if (i == CFG_TREND_THRESH)
                word[31:15] = 17'($urandom());
            if (i == CFG_VALID_LOW || i == CFG_VALID_HIGH)
                word[31:16] = 16'($urandom());
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= word;
            @(posedge clk);
        end
        cfg_index <= CFG_SPARE_6;
        cfg_data  <= $urandom();
        @(posedge clk);
        cfg_index <= CFG_SPARE_7;
        cfg_data  <= $urandom();
        @(posedge clk);
        cfg_we    <= 1'b0;
        gen_hist  = v[CFG_HIST_INTERVAL];
        gen_trend = v[CFG_TREND_INTERVAL];
        gen_stale = v[CFG_TREND_STALE];
        gen_slope = int'(v[CFG_TREND_THRESH][14:0]);
        gen_lo    = int'($signed(v[CFG_VALID_LOW][15:0]));
        gen_hi    = int'($signed(v[CFG_VALID_HIGH][15:0]));
        gen_span  = span;
        n_settings++;
    endtask

    function automatic tth_request_t random_request();
        tth_request_t rq;
        int pick;
        int lo;
        int hi;
        int val;
        pick = $urandom_range(0, 99);
        rq.kind = (pick < 45) ? REQ_UPDATE : (pick < 75) ? REQ_TREND :
                  (pick < 95) ? REQ_HIST : REQ_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            now_clock += $urandom_range(0, gen_span);
        else if (pick < 68)
            now_clock += gen_hist;
        else if (pick < 74)
            now_clock += gen_trend;
        else if (pick < 80)
            now_clock += gen_stale + 32'd1 - $urandom_range(0, 2);
        else if (pick < 85)
            now_clock = $urandom();
        else if (pick < 88)
            now_clock = '0;
        rq.now = now_clock;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            lo  = ((gen_lo < gen_hi) ? gen_lo : gen_hi) - 4;
            hi  = ((gen_lo < gen_hi) ? gen_hi : gen_lo) + 4;
            val = lo + int'($urandom_range(0, hi - lo));
        end
        else if (pick < 70)
        begin
            val = gen_slope + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1))
                val = -val;
            val += last_update_temp;
        end
        else if (pick < 78)
            val = $urandom_range(0, 1) ? gen_lo : gen_hi;
        else if (pick < 85)
            val = $urandom_range(0, 1) ? -32768 : 32767;
        else
            val = int'($urandom_range(0, 65535)) - 32768;
        if (val < -32768)
            val = -32768;
        if (val > 32767)
            val = 32767;
        rq.temp = 16'(val);
        rq.idx  = 4'($urandom_range(0, 15));
        return rq;
    endfunction

    initial
    begin : stimulus
        reg_set_t regs;
        int i;
        int ph;
        int base;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_UPDATE;
        req_ch.temp       = '0;
        req_ch.now_ms     = '0;
        req_ch.hist_index = '0;
        rsp_ch.ready      = 1'b0;
        row_fixed         = 1'b0;
        row_want          = AT_RESET;
        calm_tx           = 1'b0;
        calm_rx           = 1'b0;
        now_clock         = '0;
        last_update_temp  = 0;

        // reset register values apply to the whole table
        add_row(REQ_HIST,   0,     32'd0,          4'd0,  1'b1, AT_RESET);
        add_row(REQ_TREND,  100,   32'd5,          4'd0,  1'b1, AT_RESET);
        add_row(REQ_UNUSED, -1,    32'hFFFF_FFFF,  4'd15, 1'b1, AT_RESET);
        add_row(REQ_UPDATE, 160,   32'd0,          4'd0,  1'b1,
                '{TREND_STEADY, 16'sd160, 16'sd160, EMPTY_MARK, 3'd1, 1'b1});
        add_row(REQ_HIST,   0,     32'd0,          4'd1,  1'b0, AT_RESET);
        add_row(REQ_UPDATE, 200,   32'd1,          4'd0,  1'b0, AT_RESET);
        add_row(REQ_UPDATE, -800,  32'd2,          4'd0,  1'b0, AT_RESET);
        add_row(REQ_UPDATE, 1600,  32'd3600001,    4'd0,  1'b0, AT_RESET);
        add_row(REQ_TREND,  1600,  32'd3600001,    4'd0,  1'b0, AT_RESET);
        add_row(REQ_UPDATE, 0,     32'd4200001,    4'd0,  1'b0, AT_RESET);
        add_row(REQ_TREND,  17,    32'd4200001,    4'd0,  1'b0, AT_RESET);
        add_row(REQ_TREND,  16,    32'd4200001,    4'd0,  1'b0, AT_RESET);
        add_row(REQ_TREND,  -17,   32'd4200001,    4'd0,  1'b0, AT_RESET);
        add_row(REQ_TREND,  -16,   32'd4200001,    4'd0,  1'b0, AT_RESET);
        add_row(REQ_TREND,  17,    32'd5400001,    4'd0,  1'b0, AT_RESET);
        add_row(REQ_TREND,  17,    32'd5400002,    4'd0,  1'b0, AT_RESET);
        add_row(REQ_TREND,  -801,  32'd4200001,    4'd0,  1'b0, AT_RESET);
        add_row(REQ_TREND,  -800,  32'd4200001,    4'd0,  1'b0, AT_RESET);
        add_row(REQ_UPDATE, -32768, 32'hFFFF_FFF0, 4'd0,  1'b0, AT_RESET);
        add_row(REQ_UPDATE, 32767, 32'h0000_0010,  4'd0,  1'b0, AT_RESET);
        add_row(REQ_UPDATE, -801,  32'd3600016,    4'd0,  1'b0, AT_RESET);
        add_row(REQ_UPDATE, 1599,  32'd7200016,    4'd0,  1'b0, AT_RESET);
        add_row(REQ_UPDATE, -799,  32'd10800016,   4'd0,  1'b0, AT_RESET);
        add_row(REQ_HIST,   0,     32'd10800016,   4'd0,  1'b0, AT_RESET);
        add_row(REQ_HIST,   0,     32'd10800016,   4'd5,  1'b0, AT_RESET);
        add_row(REQ_HIST,   0,     32'd10800016,   4'd6,  1'b0, AT_RESET);
        add_row(REQ_HIST,   0,     32'd10800016,   4'd15, 1'b0, AT_RESET);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < plan.size(); i++)
            send_request(plan[i].rq, plan[i].fixed, plan[i].want);
        wait_idle();

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin
                    regs = make_regs(RST_HIST_INTERVAL, RST_TREND_INTERVAL, RST_TREND_STALE,
                                     32'(RST_TREND_THRESH), 32'(RST_VALID_LOW),
                                     32'(RST_VALID_HIGH));
                    program_regs(regs, 500000);
                end
                1: begin
                    regs = make_regs(32'd1, 32'd1, 32'd0, 32'd0, 32'h8000, 32'h7FFF);
                    program_regs(regs, 3);
                end
                2: begin
                    regs = make_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'h7FFF, 32'h7FFF, 32'h8000);
                    program_regs(regs, 1000);
                end
                default: begin
                    base = int'($urandom_range(0, 2000)) - 1000;
                    regs = make_regs($urandom_range(1, 400), $urandom_range(1, 200),
                                     $urandom_range(0, 400), $urandom_range(0, 64),
                                     32'(base), 32'(base + int'($urandom_range(0, 1500)) - 100));
                    program_regs(regs, 150);
                end
            endcase
            calm_tx = (ph == 3 || ph == 5 || ph == 6);
            calm_rx = (ph == 3 || ph == 6 || ph == 7);
            repeat (PHASE_ITEMS)
                send_request(random_request(), 1'b0, AT_RESET);
            wait_idle();
        end

        $display("Covered %0d requests under %0d register settings: %0d updates, %0d shifts,",
                 n_replies, n_settings, n_kind[REQ_UPDATE], n_shifts);
        $display("%0d trend queries (%0d rising, %0d falling), %0d history reads, %0d unused.",
                 n_kind[REQ_TREND], n_rising, n_falling, n_kind[REQ_HIST], n_kind[REQ_UNUSED]);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
